>>> rtl/adi_pkg.sv
// Shared types and constants for the audio DMA interface.
package adi_pkg;

   localparam int DATA_W  = 32;
   localparam int LEN_W   = 18;
   localparam int DAC_W   = 14;
   localparam int BIT_W   = 4;
   localparam int MADDR_W = 24;
   localparam int DIVR_W  = DAC_W + 1;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [2:0] REG_ADDR    = 3'd0;
   localparam logic [2:0] REG_LEN     = 3'd1;
   localparam logic [2:0] REG_CONTROL = 3'd2;
   localparam logic [2:0] REG_STATUS  = 3'd3;
   localparam logic [2:0] REG_DACRATE = 3'd4;
   localparam logic [2:0] REG_BITRATE = 3'd5;

   localparam logic [DATA_W-1:0] CLOCK_RATE_RESET = 32'd93750000;
   localparam logic [DATA_W-1:0] STATUS_BASE      = 32'h0110_0000;
   localparam logic [DATA_W-1:0] STATUS_FULL      = 32'h8000_0001;
   localparam logic [DATA_W-1:0] STATUS_BUSY      = 32'h4000_0000;

   typedef enum logic [2:0] {
      ST_IDLE       = 3'b001,
      ST_DIV_FREQ   = 3'b010,
      ST_DIV_PERIOD = 3'b100
   } adi_state_type;

   typedef struct packed {
      logic exec;
      logic out_load;
      logic div_start;
      logic div_period;
      logic period_load;
   } adi_cmd_type;

   typedef struct packed {
      logic dacrate_wr;
      logic div_done;
   } adi_sts_type;

endpackage

>>> rtl/adi_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
module adi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [adi_pkg::DATA_W-1:0] dividend,
   input  logic [adi_pkg::DATA_W-1:0] divisor,
   output logic [adi_pkg::DATA_W-1:0] quotient,
   output logic                       done
);
   import adi_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] quot_ff, quot_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[DATA_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in  = diff[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

>>> rtl/adi_dp.sv
// Datapath: DMA registers, transfer queue, sample timer and result register.
module adi_dp #(
   parameter int DRAM_ADDR_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  adi_pkg::adi_cmd_type        cmd,
   output adi_pkg::adi_sts_type        sts,
   input  logic [1:0]                  opcode,
   input  logic [2:0]                  reg_index,
   input  logic [adi_pkg::DATA_W-1:0]  write_data,
   input  logic                        csr_wr_en,
   input  logic [adi_pkg::DATA_W-1:0]  csr_wr_data,
   output logic [adi_pkg::DATA_W-1:0]  read_data,
   output logic                        mem_fetch,
   output logic [adi_pkg::MADDR_W-1:0] mem_address,
   output logic                        irq_raise,
   output logic                        irq_clear
);
   import adi_pkg::*;

   localparam int AW = DRAM_ADDR_BITS;

   logic [DATA_W-1:0] clk_rate_ff, clk_rate_in;
   logic [AW-1:0]     cur_addr_ff, cur_addr_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [AW-1:0]     q_addr_ff, q_addr_in;
   logic [LEN_W-1:0]  q_len_ff, q_len_in;
   logic [1:0]        pend_ff, pend_in;
   logic              run_ff, run_in;
   logic [DAC_W-1:0]  dac_ff, dac_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [DATA_W-1:0] period_ff, period_in;
   logic [DATA_W-1:0] cdown_ff, cdown_in;

   logic [DATA_W-1:0]  rdata_ff, rdata_in;
   logic               fetch_ff, fetch_in;
   logic [MADDR_W-1:0] maddr_ff, maddr_in;
   logic               raise_ff, raise_in;
   logic               clear_ff, clear_in;

   logic [AW-1:0]     addr_wr;
   logic [LEN_W-1:0]  len_wr;
   logic [LEN_W-1:0]  len_dec;
   logic [DIVR_W-1:0] dac_div;
   logic [DATA_W-1:0] div_divisor;
   logic [DATA_W-1:0] div_quot;
   logic              div_done;
   logic [DATA_W-1:0] freq;

   adi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (clk_rate_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      dac_div     = {1'b0, write_data[DAC_W-1:0]} + DIVR_W'(1);
      freq        = (div_quot == '0) ? DATA_W'(1) : div_quot;
      div_divisor = cmd.div_period ? freq : DATA_W'(dac_div);
      sts.dacrate_wr = (opcode == OP_WRITE) && (reg_index == REG_DACRATE);
      sts.div_done   = div_done;
   end

   always_comb begin
      addr_wr     = {write_data[AW-1:3], 3'b000};
      len_wr      = {write_data[LEN_W-1:3], 3'b000};
      len_dec     = cur_len_ff - LEN_W'(4);
      clk_rate_in = csr_wr_en ? csr_wr_data : clk_rate_ff;
      cur_addr_in = cur_addr_ff;
      cur_len_in  = cur_len_ff;
      q_addr_in   = q_addr_ff;
      q_len_in    = q_len_ff;
      pend_in     = pend_ff;
      run_in      = run_ff;
      dac_in      = dac_ff;
      bit_in      = bit_ff;
      period_in   = period_ff;
      cdown_in    = cdown_ff;
      rdata_in    = '0;
      fetch_in    = 1'b0;
      maddr_in    = '0;
      raise_in    = 1'b0;
      clear_in    = 1'b0;

      if (cmd.exec) begin
         case (opcode)
            OP_READ: begin
               case (reg_index)
                  REG_ADDR:    rdata_in = DATA_W'(cur_addr_ff);
                  REG_LEN:     rdata_in = DATA_W'(cur_len_ff);
                  REG_CONTROL: rdata_in = DATA_W'(run_ff);
                  REG_STATUS: begin
                     rdata_in = STATUS_BASE;
                     if (pend_ff > 2'd1) rdata_in = rdata_in | STATUS_FULL;
                     if (pend_ff > 2'd0) rdata_in = rdata_in | STATUS_BUSY;
                  end
                  REG_DACRATE: rdata_in = DATA_W'(dac_ff);
                  REG_BITRATE: rdata_in = DATA_W'(bit_ff);
                  default:     rdata_in = '0;
               endcase
            end
            OP_WRITE: begin
               case (reg_index)
                  REG_ADDR: begin
                     if (pend_ff == 2'd0) cur_addr_in = addr_wr;
                     else if (pend_ff == 2'd1) q_addr_in = addr_wr;
                  end
                  REG_LEN: begin
                     if (pend_ff < 2'd2 && len_wr != '0) begin
                        if (pend_ff == 2'd0) cur_len_in = len_wr;
                        else q_len_in = len_wr;
                        pend_in = pend_ff + 2'd1;
                     end
                  end
                  REG_CONTROL: begin
                     if (write_data[0] != run_ff) begin
                        run_in = write_data[0];
                        if (write_data[0]) cdown_in = period_ff;
                     end
                  end
                  REG_STATUS:  clear_in = 1'b1;
                  REG_DACRATE: dac_in = write_data[DAC_W-1:0];
                  REG_BITRATE: bit_in = write_data[BIT_W-1:0];
                  default: ;
               endcase
            end
            OP_TICK: begin
               if (run_ff) begin
                  if (cdown_ff > DATA_W'(1)) begin
                     cdown_in = cdown_ff - DATA_W'(1);
                  end else begin
                     cdown_in = period_ff;
                     if (pend_ff != 2'd0) begin
                        fetch_in    = 1'b1;
                        maddr_in    = cur_addr_ff[MADDR_W-1:0];
                        cur_addr_in = cur_addr_ff + AW'(4);
                        cur_len_in  = len_dec;
                        if (len_dec == '0) begin
                           raise_in = 1'b1;
                           pend_in  = pend_ff - 2'd1;
                           if (pend_ff == 2'd2) begin
                              cur_addr_in = q_addr_ff;
                              cur_len_in  = q_len_ff;
                           end
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.period_load) begin
         period_in = div_quot;
         if (run_ff) cdown_in = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_rate_ff <= CLOCK_RATE_RESET;
         cur_addr_ff <= '0;
         cur_len_ff  <= '0;
         q_addr_ff   <= '0;
         q_len_ff    <= '0;
         pend_ff     <= '0;
         run_ff      <= 1'b0;
         dac_ff      <= '0;
         bit_ff      <= '0;
         period_ff   <= '0;
         cdown_ff    <= '0;
      end else begin
         clk_rate_ff <= clk_rate_in;
         cur_addr_ff <= cur_addr_in;
         cur_len_ff  <= cur_len_in;
         q_addr_ff   <= q_addr_in;
         q_len_ff    <= q_len_in;
         pend_ff     <= pend_in;
         run_ff      <= run_in;
         dac_ff      <= dac_in;
         bit_ff      <= bit_in;
         period_ff   <= period_in;
         cdown_ff    <= cdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rdata_ff <= rdata_in;
         fetch_ff <= fetch_in;
         maddr_ff <= maddr_in;
         raise_ff <= raise_in;
         clear_ff <= clear_in;
      end
   end

   assign read_data   = rdata_ff;
   assign mem_fetch   = fetch_ff;
   assign mem_address = maddr_ff;
   assign irq_raise   = raise_ff;
   assign irq_clear   = clear_ff;

endmodule

>>> rtl/adi_ctrl.sv
// Controller: stream handshakes and sequencing of the sample period division.
module adi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  adi_pkg::adi_sts_type sts,
   output adi_pkg::adi_cmd_type cmd
);
   import adi_pkg::*;

   adi_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;
   logic          accept;

   always_comb begin
      out_free     = !out_valid_ff || rsp_tready;
      req_tready   = (state_ff == ST_IDLE) && out_free;
      accept       = req_tvalid && req_tready;
      cmd          = '0;
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.exec = 1'b1;
               if (sts.dacrate_wr) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV_FREQ;
               end else begin
                  cmd.out_load = 1'b1;
                  out_valid_in = 1'b1;
               end
            end
         end
         ST_DIV_FREQ: begin
            if (sts.div_done) begin
               cmd.div_start  = 1'b1;
               cmd.div_period = 1'b1;
               state_in       = ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            if (sts.div_done && out_free) begin
               cmd.period_load = 1'b1;
               cmd.out_load    = 1'b1;
               out_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

>>> rtl/audio_dma_interface_top.sv
// Top level of the audio DMA interface: stream ports, controller and datapath.
//
// Register reads, register writes and clock ticks each load their result in the
// cycle in which they are taken, so a new transfer can be taken every cycle
// while the result side keeps up; a result still waiting at the output holds
// off the next transfer until the cycle in which it is taken. A write to the
// dacrate register holds off the next transfer while two 32-step divisions in
// the shared one-bit-per-cycle divider derive the sample period; the second
// division starts when the first is done, and when it is done and the result
// side is free the period and the result are loaded and the controller
// returns to idle.
module audio_dma_interface_top #(
   parameter int DRAM_ADDR_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // write_data
   input  logic [4:0]  req_tuser,  // opcode[1:0], reg_index[4:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], mem_fetch[32], mem_address[56:33], irq_raise[57],
   // irq_clear[58], zero fill[63:59]
   output logic [63:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import adi_pkg::*;

   adi_cmd_type        cmd;
   adi_sts_type        sts;
   logic [DATA_W-1:0]  read_data;
   logic               mem_fetch;
   logic [MADDR_W-1:0] mem_address;
   logic               irq_raise;
   logic               irq_clear;

   adi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   adi_dp #(
      .DRAM_ADDR_BITS (DRAM_ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .opcode      (req_tuser[1:0]),
      .reg_index   (req_tuser[4:2]),
      .write_data  (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .read_data   (read_data),
      .mem_fetch   (mem_fetch),
      .mem_address (mem_address),
      .irq_raise   (irq_raise),
      .irq_clear   (irq_clear)
   );

   assign rsp_tdata = {5'b0, irq_clear, irq_raise, mem_address, mem_fetch, read_data};

   a_fetch_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mem_fetch |-> !irq_clear && read_data == '0)
      else $error("fetch result carries read data or an interrupt clear");

   a_raise_on_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && irq_raise |-> mem_fetch)
      else $error("interrupt raised without a sample fetch");

   a_word_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mem_fetch |-> mem_address[1:0] == 2'b00)
      else $error("sample fetch address is not word aligned");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && !(req_tuser[1:0] == OP_WRITE && req_tuser[4:2] == REG_DACRATE)
      |=> rsp_tvalid)
      else $error("no result after a single-cycle transfer");

endmodule

>>> dv/tb_audio_dma_interface_top.sv
// Self-checking testbench for the audio DMA interface top level.
module tb_audio_dma_interface_top;
   timeunit 1ns;
   timeprecision 1ps;

   import adi_pkg::*;

   localparam logic [1:0] OP_NONE    = 2'd3;
   localparam logic [2:0] REG_SPARE6 = 3'd6;
   localparam logic [2:0] REG_SPARE7 = 3'd7;

   localparam int RESET_CYCLES = 12;
   localparam int LONG_HOLD    = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE       = 80;
   localparam int DIR_ROWS     = 28;

   typedef struct packed {
      logic              irq_clear;
      logic              irq_raise;
      logic [MADDR_W-1:0] mem_address;
      logic              mem_fetch;
      logic [DATA_W-1:0] read_data;
   } dma_result_type;

   typedef struct {
      logic [1:0]     op;
      logic [2:0]     idx;
      logic [31:0]    data;
      logic           fixed;
      dma_result_type want;
   } dma_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   logic [MADDR_W-1:0] cur_addr;
   logic [LEN_W-1:0]   cur_len;
   logic [MADDR_W-1:0] q_addr;
   logic [LEN_W-1:0]   q_len;
   logic [1:0]         pend;
   logic               running;
   logic [DAC_W-1:0]   dac_rate_q;
   logic [BIT_W-1:0]   bit_rate_q;
   logic [31:0]        period;
   logic [31:0]        countdown;
   logic [31:0]        clk_rate;

   dma_item_type   offered_items[$];
   dma_result_type results_due[$];
   int             mismatches = 0;
   int             quiet = 0;
   bit             calm = 1'b0;
   bit             long_hold_req = 1'b0;

   dma_item_type dir_table [DIR_ROWS] = '{
      '{OP_READ,  REG_STATUS,  32'h0000_0000, 1'b1, {2'b00, 24'h0, 1'b0, STATUS_BASE}},
      '{OP_READ,  REG_ADDR,    32'h0000_0000, 1'b1, 59'd0},
      '{OP_TICK,  REG_SPARE7,  32'hFFFF_FFFF, 1'b1, 59'd0},
      '{OP_NONE,  REG_SPARE7,  32'hFFFF_FFFF, 1'b1, 59'd0},
      '{OP_WRITE, REG_STATUS,  32'hFFFF_FFFF, 1'b1, {2'b10, 24'h0, 1'b0, 32'h0}},
      '{OP_WRITE, REG_SPARE6,  32'hFFFF_FFFF, 1'b1, 59'd0},
      '{OP_READ,  REG_SPARE7,  32'h0000_0000, 1'b1, 59'd0},
      '{OP_WRITE, REG_BITRATE, 32'hFFFF_FFFF, 1'b1, 59'd0},
      '{OP_READ,  REG_BITRATE, 32'h0000_0000, 1'b1, {2'b00, 24'h0, 1'b0, 32'hF}},
      '{OP_WRITE, REG_DACRATE, 32'h0000_0000, 1'b1, 59'd0},
      '{OP_WRITE, REG_ADDR,    32'hFFFF_FFFF, 1'b1, 59'd0},
      '{OP_WRITE, REG_LEN,     32'h0000_0000, 1'b1, 59'd0},
      '{OP_WRITE, REG_LEN,     32'h0000_0010, 1'b1, 59'd0},
      '{OP_WRITE, REG_ADDR,    32'h0000_0010, 1'b1, 59'd0},
      '{OP_WRITE, REG_LEN,     32'hFFFC_0018, 1'b1, 59'd0},
      '{OP_READ,  REG_STATUS,  32'h0000_0000, 1'b1,
        {2'b00, 24'h0, 1'b0, STATUS_BASE | STATUS_FULL | STATUS_BUSY}},
      '{OP_WRITE, REG_ADDR,    32'h1234_5678, 1'b1, 59'd0},
      '{OP_READ,  REG_ADDR,    32'h0000_0000, 1'b1, {2'b00, 24'h0, 1'b0, 32'h00FF_FFF8}},
      '{OP_WRITE, REG_CONTROL, 32'h0000_0001, 1'b1, 59'd0},
      '{OP_TICK,  REG_ADDR,    32'h0000_0000, 1'b0, 59'd0},
      '{OP_TICK,  REG_ADDR,    32'h0000_0000, 1'b0, 59'd0},
      '{OP_TICK,  REG_ADDR,    32'h0000_0000, 1'b0, 59'd0},
      '{OP_TICK,  REG_ADDR,    32'h0000_0000, 1'b0, 59'd0},
      '{OP_READ,  REG_LEN,     32'h0000_0000, 1'b0, 59'd0},
      '{OP_WRITE, REG_DACRATE, 32'hFFFF_FFFF, 1'b0, 59'd0},
      '{OP_TICK,  REG_ADDR,    32'h0000_0000, 1'b0, 59'd0},
      '{OP_WRITE, REG_CONTROL, 32'hFFFF_FFFE, 1'b0, 59'd0},
      '{OP_READ,  REG_CONTROL, 32'h0000_0000, 1'b0, 59'd0}
   };

   audio_dma_interface_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic dma_result_type next_dma_result(input logic [1:0] op,
                                                      input logic [2:0] idx,
                                                      input logic [31:0] data);
      dma_result_type r;
      logic [31:0] freq;
      r = '0;
      case (op)
         OP_READ: begin
            case (idx)
               REG_ADDR:    r.read_data = 32'(cur_addr);
               REG_LEN:     r.read_data = 32'(cur_len);
               REG_CONTROL: r.read_data = 32'(running);
               REG_STATUS: begin
                  r.read_data = STATUS_BASE;
                  if (pend > 2'd1) r.read_data = r.read_data | STATUS_FULL;
                  if (pend > 2'd0) r.read_data = r.read_data | STATUS_BUSY;
               end
               REG_DACRATE: r.read_data = 32'(dac_rate_q);
               REG_BITRATE: r.read_data = 32'(bit_rate_q);
               default: r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (idx)
               REG_ADDR: begin
                  if (pend < 2'd2) begin
                     if (pend == 2'd0) cur_addr = {data[23:3], 3'b000};
                     else q_addr = {data[23:3], 3'b000};
                  end
               end
               REG_LEN: begin
                  if (pend < 2'd2 && data[17:3] != '0) begin
                     if (pend == 2'd0) cur_len = {data[17:3], 3'b000};
                     else q_len = {data[17:3], 3'b000};
                     pend = pend + 2'd1;
                  end
               end
               REG_CONTROL: begin
                  if (data[0] != running) begin
                     running = data[0];
                     if (data[0]) countdown = period;
                  end
               end
               REG_STATUS: r.irq_clear = 1'b1;
               REG_DACRATE: begin
                  dac_rate_q = data[13:0];
                  freq = clk_rate / (32'(dac_rate_q) + 32'd1);
                  if (freq == '0) freq = 32'd1;
                  period = clk_rate / freq;
                  if (running) countdown = period;
               end
               REG_BITRATE: bit_rate_q = data[3:0];
               default: ;
            endcase
         end
         OP_TICK: begin
            if (running) begin
               if (countdown > 32'd1) begin
                  countdown = countdown - 32'd1;
               end else begin
                  countdown = period;
                  if (pend != 2'd0) begin
                     r.mem_fetch = 1'b1;
                     r.mem_address = cur_addr;
                     cur_addr = cur_addr + 24'd4;
                     cur_len = cur_len - 18'd4;
                     if (cur_len == '0) begin
                        r.irq_raise = 1'b1;
                        pend = pend - 2'd1;
                        if (pend != 2'd0) begin
                           cur_addr = q_addr;
                           cur_len = q_len;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      dma_item_type   it;
      dma_result_type want;
      dma_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it = offered_items.pop_front();
            want = next_dma_result(it.op, it.idx, it.data);
            if (it.fixed) want = it.want;
            results_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[58:0];
            if (results_due.size() == 0) begin
               note_mismatch("result with nothing outstanding", got.read_data, '0);
            end else begin
               want = results_due.pop_front();
               if (got.read_data !== want.read_data)
                  note_mismatch("read_data", got.read_data, want.read_data);
               if (got.mem_fetch !== want.mem_fetch)
                  note_mismatch("mem_fetch", 32'(got.mem_fetch), 32'(want.mem_fetch));
               if (got.mem_address !== want.mem_address)
                  note_mismatch("mem_address", 32'(got.mem_address), 32'(want.mem_address));
               if (got.irq_raise !== want.irq_raise)
                  note_mismatch("irq_raise", 32'(got.irq_raise), 32'(want.irq_raise));
               if (got.irq_clear !== want.irq_clear)
                  note_mismatch("irq_clear", 32'(got.irq_clear), 32'(want.irq_clear));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic offer(input logic [1:0] op, input logic [2:0] idx, input logic [31:0] data,
                        input logic fixed, input dma_result_type want);
      offered_items.push_back(dma_item_type'{op, idx, data, fixed, want});
      req_tvalid <= 1'b1;
      req_tuser <= {idx, op};
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 11) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (offered_items.size() != 0 || results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_clock_rate(input logic [31:0] rate);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= rate;
      clk_rate = rate;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      int          n;
      int          pick;
      logic [31:0] word;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         word = $urandom();
         if (pick < 45) begin
            offer(OP_TICK, 3'($urandom_range(0, 7)), word, 1'b0, '0);
         end else if (pick < 57) begin
            if ($urandom_range(0, 3) == 0) word[23:4] = '1;
            offer(OP_WRITE, REG_ADDR, word, 1'b0, '0);
            word = $urandom();
            word[17:0] = 18'($urandom_range(1, 6) * 8);
            offer(OP_WRITE, REG_LEN, word, 1'b0, '0);
            n++;
         end else if (pick < 65) begin
            offer(OP_READ, 3'($urandom_range(0, 7)), word, 1'b0, '0);
         end else if (pick < 70) begin
            word[0] = ($urandom_range(0, 4) != 0);
            offer(OP_WRITE, REG_CONTROL, word, 1'b0, '0);
         end else if (pick < 74) begin
            offer(OP_WRITE, REG_STATUS, word, 1'b0, '0);
         end else if (pick < 78) begin
            if ($urandom_range(0, 7) != 0) word[13:0] = 14'($urandom_range(0, 3));
            offer(OP_WRITE, REG_DACRATE, word, 1'b0, '0);
         end else if (pick < 81) begin
            offer(OP_WRITE, REG_BITRATE, word, 1'b0, '0);
         end else if (pick < 84) begin
            offer(OP_WRITE, 3'($urandom_range(6, 7)), word, 1'b0, '0);
         end else if (pick < 86) begin
            offer(OP_NONE, 3'($urandom_range(0, 7)), word, 1'b0, '0);
         end else if (pick < 93) begin
            offer(OP_WRITE, REG_ADDR, word, 1'b0, '0);
         end else begin
            word[17:9] = '0;
            offer(OP_WRITE, REG_LEN, word, 1'b0, '0);
         end
         n++;
      end
   endtask

   task automatic start_sampling;
      offer(OP_WRITE, REG_DACRATE,
            {18'($urandom_range(0, 262143)), 14'($urandom_range(0, 3))}, 1'b0, '0);
      offer(OP_WRITE, REG_CONTROL, 32'h0000_0001, 1'b0, '0);
   endtask

   initial begin
      cur_addr = '0;
      cur_len = '0;
      q_addr = '0;
      q_len = '0;
      pend = '0;
      running = 1'b0;
      dac_rate_q = '0;
      bit_rate_q = '0;
      period = '0;
      countdown = '0;
      clk_rate = CLOCK_RATE_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i])
         offer(dir_table[i].op, dir_table[i].idx, dir_table[i].data,
               dir_table[i].fixed, dir_table[i].want);
      start_sampling();
      send_random(110);
      long_hold_req = 1'b1;
      send_random(110);

      set_clock_rate(32'd1);
      start_sampling();
      send_random(220);

      set_clock_rate(32'hFFFF_FFFF);
      start_sampling();
      send_random(110);
      drain();
      send_random(110);

      set_clock_rate(32'($urandom_range(1, 64)));
      start_sampling();
      send_random(220);

      set_clock_rate($urandom());
      start_sampling();
      send_random(220);

      set_clock_rate(CLOCK_RATE_RESET);
      calm = 1'b1;
      start_sampling();
      send_random(180);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/adi_pkg.sv
rtl/adi_div.sv
rtl/adi_dp.sv
rtl/adi_ctrl.sv
rtl/audio_dma_interface_top.sv
dv/tb_audio_dma_interface_top.sv
